>>> rtl/cdt_pkg.sv
package cdt_pkg;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_LOOKUP   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_APPENDED    = 2'd0,
    STAT_OVERWRITTEN = 2'd1,
    STAT_FULL        = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  localparam int unsigned IdWidth      = 11;
  localparam int unsigned HandlerWidth = 8;

  typedef struct packed {
    logic [IdWidth-1:0]      key;
    logic [HandlerWidth-1:0] handler;
  } entry_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    hit;
    logic [HandlerWidth-1:0] handler_out;
  } result_t;

endpackage

>>> rtl/cdt_if.sv
interface cdt_req_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic                                bus;
  logic [cdt_pkg::IdWidth-1:0]         frame_id;
  logic [cdt_pkg::HandlerWidth-1:0]    handler_num;

  modport source (output valid, cmd, bus, frame_id, handler_num, input ready);
  modport sink   (input valid, cmd, bus, frame_id, handler_num, output ready);
endinterface

interface cdt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic                                hit;
  logic [cdt_pkg::HandlerWidth-1:0]    handler_out;

  modport source (output valid, status, hit, handler_out, input ready);
  modport sink   (input valid, status, hit, handler_out, output ready);
endinterface

>>> rtl/cdt_tbl_mem.sv
module cdt_tbl_mem #(
  parameter int unsigned AddrWidth = 4
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AddrWidth-1:0] rd_addr_i,
  output cdt_pkg::entry_t      rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AddrWidth-1:0] wr_addr_i,
  input  cdt_pkg::entry_t      wr_data_i
);

  localparam int unsigned Depth = 2 ** AddrWidth;

  cdt_pkg::entry_t mem_q [Depth];
  cdt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/cdt_ctrl.sv
module cdt_ctrl #(
  parameter int unsigned EntriesPerBus = 8,
  parameter int unsigned SlotWidth     = 3,
  parameter int unsigned CountWidth    = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  cdt_req_if.sink                req_i,
  cdt_rsp_if.source              rsp_o,
  output logic                   rd_en_o,
  output logic [SlotWidth:0]     rd_addr_o,
  input  cdt_pkg::entry_t        rd_data_i,
  output logic                   wr_en_o,
  output logic [SlotWidth:0]     wr_addr_o,
  output cdt_pkg::entry_t        wr_data_o
);

  localparam logic [CountWidth-1:0] FullCount = CountWidth'(EntriesPerBus);

  cdt_pkg::state_e state_q, state_d;

  logic                              cmd_q, cmd_d;
  logic                              bus_q, bus_d;
  logic [cdt_pkg::IdWidth-1:0]       id_q, id_d;
  logic [cdt_pkg::HandlerWidth-1:0]  hnd_q, hnd_d;
  logic [CountWidth-1:0]             cnt_q, cnt_d;
  logic [CountWidth-1:0]             rd_idx_q, rd_idx_d;
  logic                              cmp_v_q, cmp_v_d;
  logic [SlotWidth-1:0]              cmp_idx_q, cmp_idx_d;
  logic [CountWidth-1:0]             bus_cnt_q [2];
  logic [CountWidth-1:0]             bus_cnt_d [2];
  cdt_pkg::result_t                  res_q, res_d;
  cdt_pkg::result_t                  out_q, out_d;
  logic                              out_valid_q, out_valid_d;

  logic accept;
  logic issue;
  logic match;
  logic resolve;
  logic full;

  assign accept = req_i.valid && req_i.ready;
  assign issue  = (state_q == cdt_pkg::S_SCAN) && (rd_idx_q < cnt_q);
  assign match  = cmp_v_q && (rd_data_i.key == id_q);
  assign full   = (cnt_q == FullCount);
  assign resolve = (state_q == cdt_pkg::S_SCAN) && (match || (!issue && !cmp_v_q));

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    bus_d        = bus_q;
    id_d         = id_q;
    hnd_d        = hnd_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    cmp_v_d      = cmp_v_q;
    cmp_idx_d    = cmp_idx_q;
    bus_cnt_d[0] = bus_cnt_q[0];
    bus_cnt_d[1] = bus_cnt_q[1];
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    req_i.ready  = 1'b0;
    rd_en_o      = 1'b0;
    rd_addr_o    = {bus_q, rd_idx_q[SlotWidth-1:0]};
    wr_en_o      = 1'b0;
    wr_addr_o    = {bus_q, cmp_idx_q};
    wr_data_o    = '{key: id_q, handler: hnd_q};

    // drop the delivered item first, a fresh load below overrides
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cdt_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          cmd_d     = req_i.cmd;
          bus_d     = req_i.bus;
          id_d      = req_i.frame_id;
          hnd_d     = req_i.handler_num;
          cnt_d     = bus_cnt_q[req_i.bus];
          rd_idx_d  = '0;
          cmp_v_d   = 1'b0;
          state_d   = cdt_pkg::S_SCAN;
        end
      end
      cdt_pkg::S_SCAN: begin
        // stream reads, compare the previous slot's data each cycle
        rd_en_o   = issue;
        cmp_v_d   = issue;
        cmp_idx_d = rd_idx_q[SlotWidth-1:0];
        if (issue) begin
          rd_idx_d = rd_idx_q + CountWidth'(1);
        end
        if (resolve) begin
          res_d   = '0;
          cmp_v_d = 1'b0;
          state_d = cdt_pkg::S_RESP;
          if (cmd_q == cdt_pkg::CMD_LOOKUP) begin
            res_d.hit         = match;
            res_d.handler_out = match ? rd_data_i.handler : '0;
          end else if (match) begin
            wr_en_o      = 1'b1;
            wr_addr_o    = {bus_q, cmp_idx_q};
            wr_data_o    = '{key: id_q, handler: hnd_q};
            res_d.status = cdt_pkg::STAT_OVERWRITTEN;
          end else if (full) begin
            res_d.status = cdt_pkg::STAT_FULL;
          end else begin
            wr_en_o           = 1'b1;
            wr_addr_o         = {bus_q, cnt_q[SlotWidth-1:0]};
            wr_data_o         = '{key: id_q, handler: hnd_q};
            bus_cnt_d[bus_q]  = cnt_q + CountWidth'(1);
            res_d.status      = cdt_pkg::STAT_APPENDED;
          end
        end
      end
      cdt_pkg::S_RESP: begin
        // hold the result until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = cdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cdt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cdt_pkg::S_IDLE;
      cmp_v_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      bus_cnt_q[0] <= '0;
      bus_cnt_q[1] <= '0;
    end else begin
      state_q      <= state_d;
      cmp_v_q      <= cmp_v_d;
      out_valid_q  <= out_valid_d;
      bus_cnt_q[0] <= bus_cnt_d[0];
      bus_cnt_q[1] <= bus_cnt_d[1];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    bus_q     <= bus_d;
    id_q      <= id_d;
    hnd_q     <= hnd_d;
    cnt_q     <= cnt_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.hit         = out_q.hit;
  assign rsp_o.handler_out = out_q.handler_out;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bus_cnt_q[0] <= FullCount) && (bus_cnt_q[1] <= FullCount))
    else $error("entry count beyond table size");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == cdt_pkg::S_SCAN) && resolve)
    else $error("table write outside resolution");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == cdt_pkg::S_SCAN) && !cmp_v_q && (rd_idx_q == '0))
    else $error("accepted item did not start a scan");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == cdt_pkg::S_RESP))
    else $error("result appeared without resolution");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((bus_cnt_q[0] != $past(bus_cnt_q[0])) || (bus_cnt_q[1] != $past(bus_cnt_q[1])))
      && $past(rst_ni) |-> $past(wr_en_o))
    else $error("entry count moved without a table write");

endmodule

>>> rtl/can_id_dispatch_table_top.sv
// CAN identifier dispatch table for two buses.
// req_i carries one item: cmd (register or look up), bus, frame_id and
// handler_num. rsp_o returns exactly one item per request: status, hit and
// handler_out. Both channels move an item when valid and ready are high.
// Each bus owns ENTRIES_PER_BUS slots in a single one-port-read, one-port-write
// table memory with registered read data; the entry counts sit in flops.
// An item is handled alone: it is accepted in the idle state, the controller
// streams one table read per cycle over the valid slots of its bus and
// compares each returned key in the cycle after, stopping at the first match.
// The next item is accepted in the idle state after the result is registered.
// Reset clears both entry counts, so both tables start empty; table contents
// need no clearing. If the receiver stalls, the result waits in the output
// register while the next item is accepted and scanned; that item's result
// then holds until the register drains.
module can_id_dispatch_table_top #(
  parameter int unsigned ENTRIES_PER_BUS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdt_req_if.sink     req_i,
  cdt_rsp_if.source   rsp_o
);

  localparam int unsigned SlotWidth  = (ENTRIES_PER_BUS > 1) ? $clog2(ENTRIES_PER_BUS) : 1;
  localparam int unsigned CountWidth = $clog2(ENTRIES_PER_BUS + 1);

  logic                  rd_en;
  logic [SlotWidth:0]    rd_addr;
  cdt_pkg::entry_t       rd_data;
  logic                  wr_en;
  logic [SlotWidth:0]    wr_addr;
  cdt_pkg::entry_t       wr_data;

  cdt_ctrl #(
    .EntriesPerBus (ENTRIES_PER_BUS),
    .SlotWidth     (SlotWidth),
    .CountWidth    (CountWidth)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  cdt_tbl_mem #(
    .AddrWidth (SlotWidth + 1)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Entries  = 8;
  localparam int unsigned PhaseLen = 250;
  localparam int unsigned PoolSize = 24;

  typedef struct {
    cdt_pkg::cmd_e                    cmd;
    logic                             bus;
    logic [cdt_pkg::IdWidth-1:0]      frame_id;
    logic [cdt_pkg::HandlerWidth-1:0] handler;
  } can_req_t;

  logic clk_i;
  logic rst_ni;

  cdt_req_if req_if ();
  cdt_rsp_if rsp_if ();

  can_id_dispatch_table_top #(
    .ENTRIES_PER_BUS(Entries)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of both bus tables
  logic [cdt_pkg::IdWidth-1:0]      id_table      [2][Entries];
  logic [cdt_pkg::HandlerWidth-1:0] handler_table [2][Entries];
  int unsigned                      entry_cnt     [2];

  can_req_t                    pending_reqs[$];
  cdt_pkg::result_t            expected_rsps[$];
  logic [cdt_pkg::IdWidth-1:0] id_pool[PoolSize];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;

  function automatic cdt_pkg::result_t dispatch_predict(can_req_t it);
    cdt_pkg::result_t r;
    int      slot;
    int      i;
    r    = '0;
    slot = -1;
    for (i = 0; i < int'(entry_cnt[it.bus]); i++) begin
      if (slot < 0 && id_table[it.bus][i] == it.frame_id) slot = i;
    end
    if (it.cmd == cdt_pkg::CMD_REGISTER) begin
      if (slot >= 0) begin
        handler_table[it.bus][slot] = it.handler;
        r.status = cdt_pkg::STAT_OVERWRITTEN;
      end else if (entry_cnt[it.bus] >= Entries) begin
        r.status = cdt_pkg::STAT_FULL;
      end else begin
        id_table[it.bus][entry_cnt[it.bus]]      = it.frame_id;
        handler_table[it.bus][entry_cnt[it.bus]] = it.handler;
        entry_cnt[it.bus]++;
        r.status = cdt_pkg::STAT_APPENDED;
      end
    end else if (slot >= 0) begin
      r.hit         = 1'b1;
      r.handler_out = handler_table[it.bus][slot];
    end
    return r;
  endfunction

  task automatic queue_req(cdt_pkg::cmd_e cmd, logic bus, logic [cdt_pkg::IdWidth-1:0] id,
                           logic [cdt_pkg::HandlerWidth-1:0] handler);
    can_req_t it;
    it.cmd      = cmd;
    it.bus      = bus;
    it.frame_id = id;
    it.handler  = handler;
    pending_reqs.push_back(it);
  endtask

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: present the next item once the current one has gone
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    can_req_t cur;
    can_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        cur.cmd      = cdt_pkg::cmd_e'(req_if.cmd);
        cur.bus      = req_if.bus;
        cur.frame_id = req_if.frame_id;
        cur.handler  = req_if.handler_num;
        expected_rsps.push_back(dispatch_predict(cur));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_if.valid       <= 1'b1;
          req_if.cmd         <= nxt.cmd;
          req_if.bus         <= nxt.bus;
          req_if.frame_id    <= nxt.frame_id;
          req_if.handler_num <= nxt.handler;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    cdt_pkg::result_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d hit %0d handler %0d",
                   $realtime, rsp_if.status, rsp_if.hit, rsp_if.handler_out);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          report_field("status", want.status, rsp_if.status);
          report_field("hit", want.hit, rsp_if.hit);
          report_field("handler_out", want.handler_out, rsp_if.handler_out);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned k;
    can_req_t    it;
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 48, 0, 8};
    stall_tab = '{0, 0, 48, 8};

    mismatches         = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    entry_cnt          = '{0, 0};
    rst_ni             = 1'b0;

    id_pool[0] = 11'd0;
    id_pool[1] = 11'd2047;
    id_pool[2] = 11'd1;
    id_pool[3] = 11'd1024;
    id_pool[4] = 11'h555;
    id_pool[5] = 11'h2aa;
    id_pool[6] = 11'h7fe;
    id_pool[7] = 11'h123;
    id_pool[8] = 11'h456;
    for (k = 9; k < PoolSize; k++) id_pool[k] = 11'($urandom_range(2047));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: lookups on empty tables, fill the first bus, overflow it,
    // overwrite on a full table, extremes of identifier and handler.
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b0, 11'd0,    8'd0);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'd0,    8'd0);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'd2047, 8'd255);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'd1,    8'haa);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'd1024, 8'h55);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'h555,  8'd1);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'h2aa,  8'h80);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'h7fe,  8'h7f);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'h123,  8'h10);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'h456,  8'h33);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b0, 11'h2aa,  8'd0);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b0, 11'h2aa,  8'hff);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b0, 11'd0,    8'hff);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b0, 11'd2047, 8'd0);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b0, 11'h123,  8'd0);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b0, 11'h456,  8'd0);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b1, 11'd0,    8'd0);
    queue_req(cdt_pkg::CMD_REGISTER, 1'b1, 11'd2047, 8'd0);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b1, 11'd2047, 8'd0);
    queue_req(cdt_pkg::CMD_LOOKUP,   1'b0, 11'd1,    8'd0);

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (n = 0; n < PhaseLen; n++) begin
        it.cmd = $urandom_range(1) ? cdt_pkg::CMD_LOOKUP : cdt_pkg::CMD_REGISTER;
        it.bus = 1'($urandom_range(1));
        // Mostly known identifiers so that hits and overwrites are common
        if ($urandom_range(99) < 65) it.frame_id = id_pool[$urandom_range(PoolSize - 1)];
        else it.frame_id = 11'($urandom_range(2047));
        case ($urandom_range(9))
          0: it.handler = 8'd0;
          1: it.handler = 8'd255;
          default: it.handler = 8'($urandom_range(255));
        endcase
        pending_reqs.push_back(it);
      end
      // Hold until every item has gone through and all results are back
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
        @(negedge clk_i);
    end

    repeat (3 * (Entries + 4)) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
